### design/motif_window_scanner_core_macros.svh
// assertion macros for the motif window scanner
`ifndef MOTIF_WINDOW_SCANNER_CORE_MACROS_SVH
`define MOTIF_WINDOW_SCANNER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MWS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MWS_ASSERT_SAME(lbl, ante, cons, msg)
`define MWS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### design/mws_pkg.sv
// shared types and codes for the motif window scanner
package mws_pkg;

    localparam logic [1:0] OP_BASE   = 2'd0;
    localparam logic [1:0] OP_SINGLE = 2'd1;
    localparam logic [1:0] OP_PAIR   = 2'd2;

    localparam logic [2:0] BASE_N = 3'd4;

    localparam int SCORE_BITS = 21;
    localparam int POS_BITS   = 32;
    localparam int LEN_BITS   = 6;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

endpackage

### design/motif_window_scanner_core.sv
// motif window scanner: weight matrix scan of a base stream, forward and reverse strands
//
// A base beat, a weight write or an ignored beat is taken while the scanner is idle.
// A base beat that completes a window of window_len bases free of N starts a scan
// that reads one window position per cycle from the base memory and, in the cycle
// after, the single and pair weights for both strands through two read ports of
// each weight memory; no further beat is taken until a scoring item has finished.
// Results wait in an output register, so the next beat is taken while a result is
// still stalled.

`include "motif_window_scanner_core_macros.svh"

module motif_window_scanner_core #(
    parameter int MAX_MOTIF_LEN = 32,
    parameter int WEIGHT_BITS   = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        window_len_write,
    input  logic [5:0]  window_len,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [2:0]  base_code,
    input  logic        first_of_sequence,
    input  logic [3:0]  table_row,
    input  logic [4:0]  table_column,
    input  logic signed [15:0] table_weight,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] window_start,
    output logic signed [20:0] forward_single_score,
    output logic signed [20:0] forward_pair_score,
    output logic signed [20:0] reverse_single_score,
    output logic signed [20:0] reverse_pair_score
);

    localparam int WB    = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam int CW    = (MAX_MOTIF_LEN > 1) ? $clog2(MAX_MOTIF_LEN) : 1;
    localparam int PCOLS = MAX_MOTIF_LEN / 2;
    localparam int PCW   = (PCOLS > 1) ? $clog2(PCOLS) : 1;
    localparam int KW    = $clog2(MAX_MOTIF_LEN + 1);
    localparam int SB    = mws_pkg::SCORE_BITS;
    localparam int PB    = mws_pkg::POS_BITS;
    localparam int LB    = mws_pkg::LEN_BITS;

    // memories
    logic [1:0]    win_mem    [2**CW];
    logic [WB-1:0] single_mem [4 * (2**CW)];
    logic [WB-1:0] pair_mem   [16 * (2**PCW)];

    mws_pkg::state_t state_reg, state_next;

    logic [LB-1:0] window_len_reg;
    logic [CW-1:0] wp_reg, wp_next;
    logic [KW-1:0] good_run_reg, good_run_next;
    logic [PB-1:0] pos_reg, pos_next, pos_cur;
    logic [KW-1:0] k_reg, k_next;
    logic [LB-1:0] len_reg;
    logic [CW-1:0] start_reg, end_reg;
    logic [PB-1:0] wstart_reg;

    logic          p1_v_reg, p2_v_reg;
    logic [KW-1:0] p1_k_reg;
    logic          p2_pair_reg;
    logic [1:0]    win_a_reg, win_b_reg;
    logic [WB-1:0] sf_reg, sr_reg, pf_reg, pr_reg;
    logic signed [SB-1:0] acc_sf_reg, acc_sr_reg, acc_pf_reg, acc_pr_reg;

    logic          out_valid_reg;
    logic [PB-1:0] out_start_reg;
    logic signed [SB-1:0] out_sf_reg, out_pf_reg, out_sr_reg, out_pr_reg;

    logic accept, base_beat, is_n, len_ok, scores, out_free, finish, p1_pair;
    logic [1:0]    code2;
    logic [6:0]    col_ext;
    logic [CW-1:0] colk;
    logic [PCW-1:0] pcol;

    assign accept    = in_valid && !in_stall;
    assign base_beat = accept && (operation == mws_pkg::OP_BASE);
    assign is_n      = (base_code >= mws_pkg::BASE_N);
    assign code2     = base_code[1:0];
    assign col_ext   = {2'b00, table_column};
    assign len_ok    = (window_len_reg != '0) && (int'(window_len_reg) <= MAX_MOTIF_LEN);
    assign out_free  = !out_valid_reg || !out_stall;
    assign finish    = (state_reg == mws_pkg::ST_DRAIN) && !p1_v_reg && !p2_v_reg && out_free;

    // run of N-free bases in the current sequence stands in for window contents
    always_comb
    begin
        pos_cur       = first_of_sequence ? '0 : pos_reg;
        pos_next      = (pos_cur == '1) ? pos_cur : pos_cur + 1'b1;
        good_run_next = first_of_sequence ? '0 : good_run_reg;
        if (is_n)
            good_run_next = '0;
        else if (int'(good_run_next) < MAX_MOTIF_LEN)
            good_run_next = good_run_next + 1'b1;
        wp_next = wp_reg + 1'b1;
        scores  = len_ok && (7'(good_run_next) >= {1'b0, window_len_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        unique case (state_reg)
            mws_pkg::ST_IDLE:
            begin
                if (base_beat && scores)
                begin
                    state_next = mws_pkg::ST_SCAN;
                    k_next     = '0;
                end
            end
            mws_pkg::ST_SCAN:
            begin
                k_next = k_reg + 1'b1;
                if (7'(k_reg) == 7'(len_reg) - 7'd1)
                    state_next = mws_pkg::ST_DRAIN;
            end
            mws_pkg::ST_DRAIN:
            begin
                if (finish)
                    state_next = mws_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mws_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != mws_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mws_pkg::ST_IDLE;
            window_len_reg <= LB'(16);
            wp_reg         <= '0;
            good_run_reg   <= '0;
            pos_reg        <= '0;
            k_reg          <= '0;
            p1_v_reg       <= 1'b0;
            p2_v_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (window_len_write)
                window_len_reg <= window_len;
            if (base_beat)
            begin
                wp_reg       <= wp_next;
                good_run_reg <= good_run_next;
                pos_reg      <= pos_next;
            end
            p1_v_reg <= (state_reg == mws_pkg::ST_SCAN);
            p2_v_reg <= p1_v_reg;
            if (finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // scan setup and window memory
    always_ff @(posedge clk)
    begin
        if (base_beat)
        begin
            win_mem[wp_next] <= code2;
            if (scores)
            begin
                len_reg    <= window_len_reg;
                end_reg    <= wp_next;
                start_reg  <= wp_next - CW'(window_len_reg - 6'd1);
                wstart_reg <= pos_cur - PB'(window_len_reg - 6'd1);
            end
        end
        win_a_reg <= win_mem[start_reg + CW'(k_reg)];
        win_b_reg <= win_mem[end_reg - CW'(k_reg)];
        p1_k_reg  <= k_reg;
    end

    // weight memories: complement of a base is its bitwise inverse
    assign colk    = CW'(p1_k_reg);
    assign pcol    = PCW'(p1_k_reg);
    assign p1_pair = (7'(p1_k_reg) < 7'(len_reg >> 1));

    always_ff @(posedge clk)
    begin
        if (accept && (operation == mws_pkg::OP_SINGLE) && (table_row < 4'd4)
            && (int'(col_ext) < MAX_MOTIF_LEN))
            single_mem[{table_row[1:0], col_ext[CW-1:0]}] <= table_weight[WB-1:0];
        if (accept && (operation == mws_pkg::OP_PAIR) && (int'(col_ext) < PCOLS))
            pair_mem[{table_row, col_ext[PCW-1:0]}] <= table_weight[WB-1:0];
        sf_reg      <= single_mem[{win_a_reg, colk}];
        sr_reg      <= single_mem[{~win_b_reg, colk}];
        pf_reg      <= pair_mem[{win_a_reg, win_b_reg, pcol}];
        pr_reg      <= pair_mem[{~win_b_reg, ~win_a_reg, pcol}];
        p2_pair_reg <= p1_pair;
    end

    // accumulate and hand over
    always_ff @(posedge clk)
    begin
        if (base_beat && scores)
        begin
            acc_sf_reg <= '0;
            acc_sr_reg <= '0;
            acc_pf_reg <= '0;
            acc_pr_reg <= '0;
        end
        else if (p2_v_reg)
        begin
            acc_sf_reg <= acc_sf_reg + SB'(signed'(sf_reg));
            acc_sr_reg <= acc_sr_reg + SB'(signed'(sr_reg));
            if (p2_pair_reg)
            begin
                acc_pf_reg <= acc_pf_reg + SB'(signed'(pf_reg));
                acc_pr_reg <= acc_pr_reg + SB'(signed'(pr_reg));
            end
        end
        if (finish)
        begin
            out_start_reg <= wstart_reg;
            out_sf_reg    <= acc_sf_reg;
            out_pf_reg    <= acc_pf_reg;
            out_sr_reg    <= acc_sr_reg;
            out_pr_reg    <= acc_pr_reg;
        end
    end

    assign out_valid            = out_valid_reg;
    assign window_start         = out_start_reg;
    assign forward_single_score = out_sf_reg;
    assign forward_pair_score   = out_pf_reg;
    assign reverse_single_score = out_sr_reg;
    assign reverse_pair_score   = out_pr_reg;

    `MWS_ASSERT_SAME(a_pipe_busy, p1_v_reg || p2_v_reg, state_reg != mws_pkg::ST_IDLE, "pipe busy")
    `MWS_ASSERT_SAME(a_k_range, state_reg == mws_pkg::ST_SCAN, 7'(k_reg) < 7'(len_reg), "k range")
    `MWS_ASSERT_NEXT(a_start_scan, base_beat && scores, state_reg == mws_pkg::ST_SCAN, "no scan")
    `MWS_ASSERT_NEXT(a_finish_out, finish, out_valid_reg, "finished scan gave no result")

endmodule
